>>> src/tkfv_pkg.sv
// Package for the top-k frequent values core: constants, payload structs and FSM states.
// No dependencies.
`default_nettype none
package tkfv_pkg;
    localparam int MAX_DISTINCT_DEF = 64;
    localparam int VALUE_BITS_DEF   = 32;
    localparam int COUNT_BITS_DEF   = 16;
    localparam int SAMPLE_BITS      = 32;
    localparam int TOP_BITS         = 7;
    localparam int RESULT_LIMIT     = 64;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_value;
        logic                          set_end;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] frequent_value;
        logic                          final_result;
        logic                          table_overflow;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE,
        ST_SEL_SCAN,
        ST_SEL_EMIT
    } state_t;
endpackage
`default_nettype wire

>>> src/top_k_frequent_values_core.sv
// Top level of the top-k frequent values core: counting table in memory and selection walk.
// Depends on tkfv_pkg.
`default_nettype none
// A sample is taken when start is high and busy is low. Counting walks the used table entries
// one per cycle through the memory read port and stops at a match; busy stays high until the
// sample has been counted, so no new sample is taken before then. A closing sample then runs
// one table walk per reported value. Each walk ends in one strobed result; the receiver cannot stall.
// Only entries below the fill count are ever read, so no clearing pass is needed.
module top_k_frequent_values_core #(
    parameter int MAX_DISTINCT = tkfv_pkg::MAX_DISTINCT_DEF,
    parameter int VALUE_BITS   = tkfv_pkg::VALUE_BITS_DEF,
    parameter int COUNT_BITS   = tkfv_pkg::COUNT_BITS_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire tkfv_pkg::in_item_t  in_item,
    output logic                     result_valid,
    output tkfv_pkg::out_item_t      result,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [tkfv_pkg::TOP_BITS-1:0] cfg_data
);
    localparam int AW = $clog2(MAX_DISTINCT);
    localparam int NW = $clog2(MAX_DISTINCT + 1);
    localparam int EW = VALUE_BITS + COUNT_BITS;
    localparam logic [COUNT_BITS-1:0] CMAX = '1;
    localparam int SB = tkfv_pkg::SAMPLE_BITS;
    localparam int TB = tkfv_pkg::TOP_BITS;

    logic [EW-1:0] mem [MAX_DISTINCT];
    logic [MAX_DISTINCT-1:0] taken_reg, taken_next;

    tkfv_pkg::state_t state_reg, state_next;
    logic [VALUE_BITS-1:0] samp_reg, samp_next;
    logic                  end_reg, end_next;
    logic [NW-1:0]         used_reg, used_next;
    logic                  ovf_reg, ovf_next;
    logic [TB-1:0]         top_reg, top_next;
    logic [NW-1:0]         idx_reg, idx_next;
    logic [NW-1:0]         rd_reg, rd_next;
    logic                  rdv_reg, rdv_next;
    logic [TB-1:0]         left_reg, left_next;
    logic                  have_reg, have_next;
    logic [AW-1:0]         best_reg, best_next;
    logic [VALUE_BITS-1:0] bval_reg, bval_next;
    logic [COUNT_BITS-1:0] bcnt_reg, bcnt_next;

    logic [EW-1:0]         rdata_reg;
    logic                  we;
    logic [AW-1:0]         waddr;
    logic [EW-1:0]         wdata;
    logic [VALUE_BITS-1:0] rval;
    logic [COUNT_BITS-1:0] rcnt;
    logic [VALUE_BITS-1:0] samp_in;
    logic [SB-1:0]         ext_val;
    logic                  better;
    logic [TB-1:0]         want;
    logic [NW-1:0]         rd_last;

    assign rval = rdata_reg[EW-1:COUNT_BITS];
    assign rcnt = rdata_reg[COUNT_BITS-1:0];
    assign cfg_ready = (state_reg == tkfv_pkg::ST_IDLE);
    assign busy = (state_reg != tkfv_pkg::ST_IDLE);

    generate
        if (VALUE_BITS >= SB)
        begin : g_wide
            assign samp_in = VALUE_BITS'(signed'(in_item.sample_value));
            assign ext_val = bval_reg[SB-1:0];
        end
        else
        begin : g_narrow
            assign samp_in = in_item.sample_value[VALUE_BITS-1:0];
            assign ext_val = SB'(signed'(bval_reg));
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[rd_next[AW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tkfv_pkg::ST_IDLE;
            used_reg  <= '0;
            ovf_reg   <= 1'b0;
            top_reg   <= TB'(1);
            taken_reg <= '0;
            rdv_reg   <= 1'b0;
            have_reg  <= 1'b0;
            left_reg  <= '0;
            idx_reg   <= '0;
            rd_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            used_reg  <= used_next;
            ovf_reg   <= ovf_next;
            top_reg   <= top_next;
            taken_reg <= taken_next;
            rdv_reg   <= rdv_next;
            have_reg  <= have_next;
            left_reg  <= left_next;
            idx_reg   <= idx_next;
            rd_reg    <= rd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        samp_reg <= samp_next;
        end_reg  <= end_next;
        best_reg <= best_next;
        bval_reg <= bval_next;
        bcnt_reg <= bcnt_next;
    end

    always_comb
    begin
        better = !have_reg || (rcnt > bcnt_reg) ||
                 ((rcnt == bcnt_reg) && ($signed(rval) < $signed(bval_reg)));
        want = (top_reg == '0) ? TB'(1) : top_reg;
        if (NW <= TB)
        begin
            if (TB'(used_reg) < want)
            begin
                want = TB'(used_reg);
            end
        end
        else if (used_reg < NW'(want))
        begin
            want = TB'(used_reg);
        end
        if (want > TB'(tkfv_pkg::RESULT_LIMIT))
        begin
            want = TB'(tkfv_pkg::RESULT_LIMIT);
        end
        rd_last = used_reg - NW'(1);
    end

    always_comb
    begin
        state_next   = state_reg;
        samp_next    = samp_reg;
        end_next     = end_reg;
        used_next    = used_reg;
        ovf_next     = ovf_reg;
        top_next     = top_reg;
        taken_next   = taken_reg;
        rdv_next     = 1'b0;
        have_next    = have_reg;
        left_next    = left_reg;
        idx_next     = idx_reg;
        rd_next      = rd_reg;
        best_next    = best_reg;
        bval_next    = bval_reg;
        bcnt_next    = bcnt_reg;
        we           = 1'b0;
        waddr        = '0;
        wdata        = '0;
        result_valid = 1'b0;
        result.frequent_value = ext_val;
        result.final_result   = (left_reg == TB'(1));
        result.table_overflow = ovf_reg;
        case (state_reg)
            tkfv_pkg::ST_IDLE:
            begin
                if (cfg_valid)
                begin
                    top_next = cfg_data;
                end
                if (start)
                begin
                    samp_next = samp_in;
                    end_next  = in_item.set_end;
                    rd_next   = '0;
                    rdv_next  = (used_reg != '0);
                    state_next = (used_reg != '0) ? tkfv_pkg::ST_SCAN : tkfv_pkg::ST_UPDATE;
                    idx_next  = '0;
                end
            end
            tkfv_pkg::ST_SCAN:
            begin
                if (rdv_reg)
                begin
                    if (rval == samp_reg)
                    begin
                        best_next  = AW'(idx_reg);
                        bcnt_next  = rcnt;
                        have_next  = 1'b1;
                        state_next = tkfv_pkg::ST_UPDATE;
                    end
                    else
                    begin
                        idx_next = idx_reg + NW'(1);
                        if (idx_reg == rd_last)
                        begin
                            state_next = tkfv_pkg::ST_UPDATE;
                        end
                    end
                end
                if (rd_reg != rd_last && state_next == tkfv_pkg::ST_SCAN)
                begin
                    rd_next  = rd_reg + NW'(1);
                    rdv_next = 1'b1;
                end
                else
                begin
                    rdv_next = (state_next == tkfv_pkg::ST_SCAN) ? 1'b0 : 1'b0;
                end
            end
            tkfv_pkg::ST_UPDATE:
            begin
                if (have_reg)
                begin
                    we    = (bcnt_reg != CMAX);
                    waddr = best_reg;
                    wdata = {samp_reg, bcnt_reg + COUNT_BITS'(1)};
                end
                else if (used_reg != NW'(MAX_DISTINCT))
                begin
                    we        = 1'b1;
                    waddr     = AW'(used_reg);
                    wdata     = {samp_reg, COUNT_BITS'(1)};
                    used_next = used_reg + NW'(1);
                end
                else
                begin
                    ovf_next = 1'b1;
                end
                have_next = 1'b0;
                if (end_reg)
                begin
                    state_next = tkfv_pkg::ST_SEL_SCAN;
                    taken_next = '0;
                    rd_next    = '0;
                    rdv_next   = 1'b0;
                    idx_next   = '0;
                end
                else
                begin
                    state_next = tkfv_pkg::ST_IDLE;
                end
            end
            tkfv_pkg::ST_SEL_SCAN:
            begin
                if (left_reg == '0 && !rdv_reg && idx_reg == '0)
                begin
                    left_next = want;
                    rd_next   = '0;
                    rdv_next  = 1'b1;
                end
                else
                begin
                    if (rdv_reg)
                    begin
                        if (!taken_reg[AW'(idx_reg)] && better)
                        begin
                            have_next = 1'b1;
                            best_next = AW'(idx_reg);
                            bval_next = rval;
                            bcnt_next = rcnt;
                        end
                        idx_next = idx_reg + NW'(1);
                        if (idx_reg == rd_last)
                        begin
                            state_next = tkfv_pkg::ST_SEL_EMIT;
                        end
                    end
                    if (rd_reg != rd_last)
                    begin
                        rd_next  = rd_reg + NW'(1);
                        rdv_next = 1'b1;
                    end
                end
            end
            tkfv_pkg::ST_SEL_EMIT:
            begin
                result_valid = 1'b1;
                taken_next[best_reg] = 1'b1;
                have_next = 1'b0;
                left_next = left_reg - TB'(1);
                rd_next   = '0;
                idx_next  = '0;
                if (left_reg == TB'(1))
                begin
                    state_next = tkfv_pkg::ST_IDLE;
                    used_next  = '0;
                    ovf_next   = 1'b0;
                    left_next  = '0;
                end
                else
                begin
                    state_next = tkfv_pkg::ST_SEL_SCAN;
                    rdv_next   = 1'b1;
                end
            end
            default:
            begin
                state_next = tkfv_pkg::ST_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

>>> src/tkfv_checker.sv
// Port-level checker for the top-k frequent values core, with its bind statement.
// Depends on tkfv_pkg and top_k_frequent_values_core.
`default_nettype none
module tkfv_checker (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                start,
    input wire logic                busy,
    input wire logic                result_valid,
    input wire tkfv_pkg::out_item_t result,
    input wire logic                cfg_ready
);
    a_idle_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |-> !result_valid) else $error("result while idle");
    a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready == !busy) else $error("config ready while busy");
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy) else $error("accepted beat did not raise busy");
    a_final_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.final_result) |=> !busy) else $error("no idle after final");
endmodule

bind top_k_frequent_values_core tkfv_checker u_tkfv_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .result_valid(result_valid), .result(result), .cfg_ready(cfg_ready)
);
`default_nettype wire

>>> test/top_k_frequent_values_core_test.sv
// Self-checking testbench for the top-k frequent values core: sets of samples are driven,
// the reported values are predicted and compared beat by beat. Depends on tkfv_pkg and the core.
`default_nettype none
module top_k_frequent_values_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_DEPTH = tkfv_pkg::MAX_DISTINCT_DEF;
    localparam int COUNT_MAX = (1 << tkfv_pkg::COUNT_BITS_DEF) - 1;
    localparam int CYCLE_LIMIT = 10000000;
    localparam int DRAIN_CYCLES = 200;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    tkfv_pkg::in_item_t in_item = '0;
    logic result_valid;
    tkfv_pkg::out_item_t result;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [tkfv_pkg::TOP_BITS-1:0] cfg_data = '0;

    top_k_frequent_values_core u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
        .result_valid(result_valid), .result(result), .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    tkfv_pkg::in_item_t pending_samples[$];
    tkfv_pkg::out_item_t expected_reports[$];
    logic signed [tkfv_pkg::SAMPLE_BITS-1:0] seen_values[TABLE_DEPTH];
    int seen_counts[TABLE_DEPTH];
    int distinct_used = 0;
    bit dropped_value = 1'b0;
    int report_len = 1;
    int error_count = 0;
    int cycle_count = 0;
    int sets_closed = 0;
    int reports_checked = 0;
    int burst_left = 0;
    int gap_left = 0;
    logic took_beat = 1'b0;

    task automatic enqueue_sample(input tkfv_pkg::in_item_t item);
        pending_samples = {pending_samples, item};
    endtask

    task automatic count_sample(input tkfv_pkg::in_item_t item);
        int i;
        int want;
        int best;
        bit found;
        bit taken[TABLE_DEPTH];
        tkfv_pkg::out_item_t rep;
        found = 1'b0;
        for (i = 0; i < distinct_used; i++)
        begin
            if (!found && seen_values[i] == item.sample_value)
            begin
                if (seen_counts[i] < COUNT_MAX)
                    seen_counts[i]++;
                found = 1'b1;
            end
        end
        if (!found)
        begin
            if (distinct_used < TABLE_DEPTH)
            begin
                seen_values[distinct_used] = item.sample_value;
                seen_counts[distinct_used] = 1;
                distinct_used++;
            end
            else
                dropped_value = 1'b1;
        end
        if (item.set_end)
        begin
            want = (report_len == 0) ? 1 : report_len;
            if (want > distinct_used)
                want = distinct_used;
            if (want > tkfv_pkg::RESULT_LIMIT)
                want = tkfv_pkg::RESULT_LIMIT;
            for (i = 0; i < TABLE_DEPTH; i++)
                taken[i] = 1'b0;
            for (int k = 0; k < want; k++)
            begin
                best = -1;
                for (i = 0; i < distinct_used; i++)
                begin
                    if (!taken[i] && (best < 0 || seen_counts[i] > seen_counts[best] ||
                        (seen_counts[i] == seen_counts[best] &&
                         seen_values[i] < seen_values[best])))
                        best = i;
                end
                taken[best] = 1'b1;
                rep.frequent_value = seen_values[best];
                rep.final_result = (k + 1 == want);
                rep.table_overflow = dropped_value;
                expected_reports = {expected_reports, rep};
            end
            distinct_used = 0;
            dropped_value = 1'b0;
            sets_closed++;
        end
    endtask

    always @(posedge clk)
    begin
        took_beat <= start && !busy && rst_n;
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (took_beat || !start)
            begin
                if (took_beat)
                    void'(pending_samples.pop_front());
                if (gap_left > 0)
                begin
                    gap_left--;
                    start <= 1'b0;
                end
                else if (pending_samples.size() > 0)
                begin
                    if (burst_left == 0)
                    begin
                        burst_left = $urandom_range(1, 12);
                        if ($urandom_range(0, 3) != 0)
                            gap_left = $urandom_range(0, 6);
                    end
                    if (gap_left > 0)
                        start <= 1'b0;
                    else
                    begin
                        burst_left--;
                        start <= 1'b1;
                        in_item <= pending_samples[0];
                    end
                end
                else
                    start <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (rst_n && start && !busy)
            count_sample(in_item);
        if (rst_n && result_valid)
        begin
            if (expected_reports.size() == 0)
            begin
                $display("%0t: unexpected result value=%0d final=%0b ovf=%0b", $time,
                         result.frequent_value, result.final_result, result.table_overflow);
                error_count++;
            end
            else
            begin
                if (result !== expected_reports[0])
                begin
                    $display("%0t: mismatch expected value=%0d final=%0b ovf=%0b", $time,
                             expected_reports[0].frequent_value,
                             expected_reports[0].final_result,
                             expected_reports[0].table_overflow);
                    $display("%0t:          actual   value=%0d final=%0b ovf=%0b", $time,
                             result.frequent_value, result.final_result,
                             result.table_overflow);
                    error_count++;
                end
                void'(expected_reports.pop_front());
                reports_checked++;
            end
        end
    end

    always @(posedge clk)
    begin
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("top_k_frequent_values_core verification failed");
            $finish;
        end
    end

    function automatic tkfv_pkg::in_item_t make_sample(input int value, input bit last);
        tkfv_pkg::in_item_t item;
        item.sample_value = value;
        item.set_end = last;
        return item;
    endfunction

    task automatic wait_idle();
        while (pending_samples.size() > 0 || start || busy || expected_reports.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_top_count(input int value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= tkfv_pkg::TOP_BITS'(value);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        report_len = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic queue_random_set(input int length, input int spread);
        int base;
        base = int'($urandom);
        for (int i = 0; i < length; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                enqueue_sample(make_sample(int'($urandom), i == length - 1));
            else
                enqueue_sample(make_sample(base + int'($urandom_range(0, spread)),
                                           i == length - 1));
        end
    endtask

    int random_count;
    int phase_sizes[6] = '{1, 64, 5, 0, 127, 3};

    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        enqueue_sample(make_sample(32'sh7fffffff, 1'b0));
        enqueue_sample(make_sample(32'sh80000000, 1'b0));
        enqueue_sample(make_sample(32'sh80000000, 1'b0));
        enqueue_sample(make_sample(-1, 1'b0));
        enqueue_sample(make_sample(0, 1'b1));
        enqueue_sample(make_sample(42, 1'b1));
        wait_idle();
        write_top_count(64);
        enqueue_sample(make_sample(-5, 1'b0));
        enqueue_sample(make_sample(5, 1'b0));
        enqueue_sample(make_sample(32'sh7fffffff, 1'b0));
        enqueue_sample(make_sample(32'sh80000000, 1'b0));
        enqueue_sample(make_sample(5, 1'b0));
        enqueue_sample(make_sample(-5, 1'b1));
        for (int i = 0; i < 66; i++)
            enqueue_sample(make_sample(i * 3 - 90, i == 65));
        wait_idle();
        random_count = 0;
        for (int p = 0; p < 6; p++)
        begin
            write_top_count(phase_sizes[p]);
            while (random_count < (p + 1) * 52)
            begin
                int len;
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 70)
                                                 : $urandom_range(1, 14);
                queue_random_set(len, $urandom_range(0, 1) ? 3 : 40);
                random_count += len;
            end
            wait_idle();
        end
        $display("Closed %0d sets and checked %0d reported values over six top_count settings.",
                 sets_closed, reports_checked);
        if (error_count == 0)
            $display("top_k_frequent_values_core verification clean");
        else
            $display("top_k_frequent_values_core verification failed");
        $finish;
    end
endmodule
`default_nettype wire
